### rtl/sgd_momentum_update_unit_defines.svh
// Assertion helpers shared by the block's modules.
// Each macro expects a clk and an rst_n in the enclosing module.
`ifndef SGD_MOMENTUM_UPDATE_UNIT_DEFINES_SVH
`define SGD_MOMENTUM_UPDATE_UNIT_DEFINES_SVH

// same-cycle implication
`define SGDMU_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SGDMU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/sgdmu_pkg.sv
`timescale 1ns / 1ps
package sgdmu_pkg;

  localparam int IDX_W     = 12;
  localparam int DATA_W    = 32;
  localparam int CFG_W     = 17;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_W-1:0] LR_RESET = 17'd655;

  typedef logic [IDX_W-1:0]         idx_t;
  typedef logic signed [DATA_W-1:0] data_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LEARNING_RATE = 3'd0,
    REG_MOMENTUM      = 3'd1,
    REG_DAMPENING     = 3'd2,
    REG_DECAY         = 3'd3,
    REG_NESTEROV      = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    data_t new_param;
    idx_t  index_out;
  } result_t;

  localparam data_t DATA_MAX = 32'sh7fff_ffff;
  localparam data_t DATA_MIN = 32'sh8000_0000;

  // saturate a one-bit-grown sum back to the data width
  function automatic data_t sat_data(input logic signed [DATA_W:0] v);
    data_t r;
    if (v[DATA_W] != v[DATA_W-1]) begin
      r = v[DATA_W] ? DATA_MIN : DATA_MAX;
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

### rtl/sgdmu_if.sv
`timescale 1ns / 1ps
interface sgdmu_in_if import sgdmu_pkg::*; ();
  logic  valid;
  logic  ready;
  idx_t  element_index;
  data_t param_value;
  data_t grad_value;
  logic  grad_present;

  modport source (output valid, element_index, param_value, grad_value, grad_present,
                  input ready);
  modport sink (input valid, element_index, param_value, grad_value, grad_present,
                output ready);
endinterface

interface sgdmu_out_if import sgdmu_pkg::*; ();
  logic  valid;
  logic  ready;
  data_t new_param;
  idx_t  index_out;

  modport source (output valid, new_param, index_out, input ready);
  modport sink (input valid, new_param, index_out, output ready);
endinterface

### rtl/sgdmu_ram.sv
`timescale 1ns / 1ps
module sgdmu_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 4096
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns the old word on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/sgdmu_fifo.sv
`timescale 1ns / 1ps
`include "sgd_momentum_update_unit_defines.svh"
module sgdmu_fifo import sgdmu_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  result_t push_data,
  output logic    pop_valid,
  input  logic    pop_ready,
  output result_t pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  result_t          mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             pop;

  assign pop_valid = (count_r != '0);
  assign pop       = pop_valid && pop_ready;
  assign pop_data  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  `SGDMU_ASSERT_NOW(a_fifo_no_overflow, push && !pop, count_r < CNT_W'(DEPTH), "fifo overflow")
  `SGDMU_ASSERT_NEXT(a_fifo_count_up, push && !pop, count_r == $past(count_r) + 1'b1, "count up")
  `SGDMU_ASSERT_NEXT(a_fifo_count_dn, pop && !push, count_r == $past(count_r) - 1'b1, "count dn")

endmodule

### rtl/sgd_momentum_update_unit.sv
`timescale 1ns / 1ps
// SGD step with momentum, one parameter element per transfer.
// in_ch carries element_index, param_value, grad_value and grad_present; out_ch
// returns new_param and index_out, one result per input, in input order.
// cfg_we/cfg_index/cfg_wdata write the coefficient registers; write them only
// while no element is in flight.
// Path: a result passes p1 to p8 and the result FIFO before it is offered, later
// if the output holds earlier results. Throughput: one element per cycle while
// in_ch.ready is high, set by the momentum read-modify-write (RAM read, forward,
// multiply-add, write). The eight-stage pipeline never stalls; a 16-entry result
// FIFO behind it and a credit count gate in_ch.ready, so inputs keep flowing
// while a result waits and stop only when 16 elements are in flight or queued.
// Reset: a clearing pass writes every momentum entry invalid, one entry per
// cycle, all ELEMENTS entries (4096 by default); in_ch.ready stays low meanwhile.
// Configuration writes are taken during the pass.
// A stalled receiver holds the head of the FIFO; nothing is dropped or repeated.
`include "sgd_momentum_update_unit_defines.svh"
module sgd_momentum_update_unit import sgdmu_pkg::*; #(
  parameter int ELEMENTS  = 4096,
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  sgdmu_in_if.sink             in_ch,
  sgdmu_out_if.source          out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  localparam int SLOT_W     = (ELEMENTS > 1) ? $clog2(ELEMENTS) : 1;
  localparam int COEF_W     = (FRAC_BITS + 1 > CFG_W) ? FRAC_BITS + 1 : CFG_W;
  localparam int PROD_W     = DATA_W + COEF_W + 1;
  localparam int FIFO_DEPTH = 16;
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
  localparam int RED_W      = 33;
  localparam logic [COEF_W-1:0] COEF_ONE = COEF_W'(1) << FRAC_BITS;

  typedef logic [COEF_W-1:0]        coef_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic [SLOT_W-1:0]        slot_t;

  function automatic coef_t clamp_coef(input logic [CFG_W-1:0] c);
    coef_t w;
    w = COEF_W'(c);
    return (w > COEF_ONE) ? COEF_ONE : w;
  endfunction

  function automatic prod_t mul_coef(input data_t v, input coef_t c);
    prod_t a;
    prod_t b;
    a = PROD_W'(v);
    b = PROD_W'($signed({1'b0, c}));
    return a * b;
  endfunction

  // coefficient is at most one, so the floored product fits the data width
  function automatic data_t shr_prod(input prod_t p);
    prod_t s;
    s = p >>> FRAC_BITS;
    return s[DATA_W-1:0];
  endfunction

  function automatic data_t add_sat(input data_t a, input data_t b);
    logic signed [DATA_W:0] s;
    s = (DATA_W+1)'(a) + (DATA_W+1)'(b);
    return sat_data(s);
  endfunction

  function automatic data_t sub_sat(input data_t a, input data_t b);
    logic signed [DATA_W:0] s;
    s = (DATA_W+1)'(a) - (DATA_W+1)'(b);
    return sat_data(s);
  endfunction

  // ---------------- configuration ----------------
  coef_t lr_r, mom_r, damp_r, wd_r;
  logic  nest_r;
  logic  mom_on;

  assign mom_on = (mom_r != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lr_r   <= clamp_coef(LR_RESET);
      mom_r  <= '0;
      damp_r <= '0;
      wd_r   <= '0;
      nest_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_LEARNING_RATE: lr_r   <= clamp_coef(cfg_wdata);
        REG_MOMENTUM:      mom_r  <= clamp_coef(cfg_wdata);
        REG_DAMPENING:     damp_r <= clamp_coef(cfg_wdata);
        REG_DECAY:         wd_r   <= clamp_coef(cfg_wdata);
        REG_NESTEROV:      nest_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // ---------------- clearing pass and credits ----------------
  logic             clr_active_r;
  slot_t            clr_addr_r;
  logic [CNT_W-1:0] used_r;
  logic             in_fire;
  logic             out_fire;

  assign in_ch.ready = !clr_active_r && (used_r < CNT_W'(FIFO_DEPTH));
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_fire    = out_ch.valid && out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
      used_r       <= '0;
    end else begin
      if (clr_active_r) begin
        clr_addr_r <= clr_addr_r + 1'b1;
        if (clr_addr_r == SLOT_W'(ELEMENTS - 1)) begin
          clr_active_r <= 1'b0;
        end
      end
      if (in_fire && !out_fire) begin
        used_r <= used_r + 1'b1;
      end else if (out_fire && !in_fire) begin
        used_r <= used_r - 1'b1;
      end
    end
  end

  // ---------------- index reduction, two halves ----------------
  logic [RED_W-1:0] red_a;
  logic [RED_W-1:0] red_b;
  idx_t             p1_red_r;

  always_comb begin
    red_a = RED_W'(in_ch.element_index);
    for (int k = IDX_W - 1; k >= IDX_W / 2; k--) begin
      if (red_a >= (RED_W'(ELEMENTS) << k)) begin
        red_a = red_a - (RED_W'(ELEMENTS) << k);
      end
    end
  end

  always_comb begin
    red_b = RED_W'(p1_red_r);
    for (int k = IDX_W / 2 - 1; k >= 0; k--) begin
      if (red_b >= (RED_W'(ELEMENTS) << k)) begin
        red_b = red_b - (RED_W'(ELEMENTS) << k);
      end
    end
  end

  // ---------------- pipeline registers ----------------
  logic  p1_v_r, p2_v_r, p3_v_r, p4_v_r, p5_v_r, p6_v_r, p7_v_r, p8_v_r;
  idx_t  p1_idx_r, p2_idx_r, p3_idx_r, p4_idx_r, p5_idx_r, p6_idx_r, p7_idx_r, p8_idx_r;
  data_t p1_param_r, p2_param_r, p3_param_r, p4_param_r;
  data_t p5_param_r, p6_param_r, p7_param_r, p8_param_r;
  logic  p1_pres_r, p2_pres_r, p3_pres_r, p4_pres_r, p5_pres_r, p6_pres_r;
  logic  p7_pres_r, p8_pres_r;
  data_t p1_grad_r, p2_grad_r;
  slot_t p2_slot_r, p3_slot_r, p4_slot_r, p5_slot_r;
  prod_t p2_wdprod_r;
  data_t p3_d_r, p4_d_r, p5_d_r, p6_d_r;
  prod_t p4_pd_r;
  data_t p5_buf_r, p6_buf_r;
  logic  p5_wr_r;
  prod_t p6_nprod_r;
  data_t p7_dir_r;
  prod_t p8_lrprod_r;

  // momentum read-modify-write
  logic [DATA_W:0] ram_rdata;
  logic [DATA_W:0] ram_wdata;
  slot_t           ram_waddr;
  logic            ram_we;
  logic            p4_wr;
  logic            fwd;
  data_t           old_buf;
  logic            old_vld;
  prod_t           mprod;
  data_t           buf_nxt;
  data_t           d_nxt;
  data_t           dir_nxt;
  data_t           res_nxt;
  result_t         push_data;

  assign p4_wr   = p4_v_r && p4_pres_r && mom_on;
  // the element one ahead wrote at the edge this read was sampled
  assign fwd     = p5_wr_r && (p5_slot_r == p4_slot_r);
  assign old_buf = fwd ? p5_buf_r : ram_rdata[DATA_W-1:0];
  assign old_vld = fwd || ram_rdata[DATA_W];
  assign mprod   = mul_coef(old_buf, mom_r);
  assign buf_nxt = old_vld ? add_sat(shr_prod(mprod), shr_prod(p4_pd_r)) : p4_d_r;

  assign ram_we    = clr_active_r || p4_wr;
  assign ram_waddr = clr_active_r ? clr_addr_r : p4_slot_r;
  assign ram_wdata = clr_active_r ? '0 : {1'b1, buf_nxt};

  assign d_nxt = (wd_r != '0) ? add_sat(p2_grad_r, shr_prod(p2_wdprod_r)) : p2_grad_r;

  always_comb begin
    if (!mom_on) begin
      dir_nxt = p6_d_r;
    end else if (nest_r) begin
      dir_nxt = add_sat(p6_d_r, shr_prod(p6_nprod_r));
    end else begin
      dir_nxt = p6_buf_r;
    end
  end

  assign res_nxt = p8_pres_r ? sub_sat(p8_param_r, shr_prod(p8_lrprod_r)) : p8_param_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r  <= 1'b0;
      p2_v_r  <= 1'b0;
      p3_v_r  <= 1'b0;
      p4_v_r  <= 1'b0;
      p5_v_r  <= 1'b0;
      p6_v_r  <= 1'b0;
      p7_v_r  <= 1'b0;
      p8_v_r  <= 1'b0;
      p5_wr_r <= 1'b0;
    end else begin
      p1_v_r  <= in_fire;
      p2_v_r  <= p1_v_r;
      p3_v_r  <= p2_v_r;
      p4_v_r  <= p3_v_r;
      p5_v_r  <= p4_v_r;
      p6_v_r  <= p5_v_r;
      p7_v_r  <= p6_v_r;
      p8_v_r  <= p7_v_r;
      p5_wr_r <= p4_wr;
    end
  end

  always_ff @(posedge clk) begin
    p1_idx_r    <= in_ch.element_index;
    p1_param_r  <= in_ch.param_value;
    p1_grad_r   <= in_ch.grad_value;
    p1_pres_r   <= in_ch.grad_present;
    p1_red_r    <= red_a[IDX_W-1:0];

    p2_idx_r    <= p1_idx_r;
    p2_param_r  <= p1_param_r;
    p2_grad_r   <= p1_grad_r;
    p2_pres_r   <= p1_pres_r;
    p2_slot_r   <= red_b[SLOT_W-1:0];
    p2_wdprod_r <= mul_coef(p1_param_r, wd_r);

    p3_idx_r    <= p2_idx_r;
    p3_param_r  <= p2_param_r;
    p3_pres_r   <= p2_pres_r;
    p3_slot_r   <= p2_slot_r;
    p3_d_r      <= d_nxt;

    p4_idx_r    <= p3_idx_r;
    p4_param_r  <= p3_param_r;
    p4_pres_r   <= p3_pres_r;
    p4_slot_r   <= p3_slot_r;
    p4_d_r      <= p3_d_r;
    p4_pd_r     <= mul_coef(p3_d_r, COEF_ONE - damp_r);

    p5_idx_r    <= p4_idx_r;
    p5_param_r  <= p4_param_r;
    p5_pres_r   <= p4_pres_r;
    p5_slot_r   <= p4_slot_r;
    p5_d_r      <= p4_d_r;
    p5_buf_r    <= buf_nxt;

    p6_idx_r    <= p5_idx_r;
    p6_param_r  <= p5_param_r;
    p6_pres_r   <= p5_pres_r;
    p6_d_r      <= p5_d_r;
    p6_buf_r    <= p5_buf_r;
    p6_nprod_r  <= mul_coef(p5_buf_r, mom_r);

    p7_idx_r    <= p6_idx_r;
    p7_param_r  <= p6_param_r;
    p7_pres_r   <= p6_pres_r;
    p7_dir_r    <= dir_nxt;

    p8_idx_r    <= p7_idx_r;
    p8_param_r  <= p7_param_r;
    p8_pres_r   <= p7_pres_r;
    p8_lrprod_r <= mul_coef(p7_dir_r, lr_r);
  end

  sgdmu_ram #(
    .WIDTH (DATA_W + 1),
    .DEPTH (ELEMENTS)
  ) u_mom_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (p3_slot_r),
    .rdata (ram_rdata)
  );

  // ---------------- result queue ----------------
  result_t pop_data;

  assign push_data.new_param = res_nxt;
  assign push_data.index_out = p8_idx_r;

  sgdmu_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (p8_v_r),
    .push_data (push_data),
    .pop_valid (out_ch.valid),
    .pop_ready (out_ch.ready),
    .pop_data  (pop_data)
  );

  assign out_ch.new_param = pop_data.new_param;
  assign out_ch.index_out = pop_data.index_out;

  `SGDMU_ASSERT_NOW(a_credit_bound, 1'b1, used_r <= CNT_W'(FIFO_DEPTH), "credit overrun")
  `SGDMU_ASSERT_NOW(a_no_item_in_clear, p4_v_r || p1_v_r, !clr_active_r, "item during clear")
  `SGDMU_ASSERT_NOW(a_out_has_credit, out_ch.valid, used_r != '0, "result without credit")

endmodule
